/* design/line_follower_stepper_drive_defines.svh */
// Assertion macros for the line follower stepper drive.
`ifndef LINE_FOLLOWER_STEPPER_DRIVE_DEFINES_SVH
`define LINE_FOLLOWER_STEPPER_DRIVE_DEFINES_SVH

`ifndef ASSERT_OFF

`define LFSD_ASSERT_IMPLIES(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |-> (cons)) else $error("lfsd: same-cycle check failed");

`define LFSD_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |=> (cons)) else $error("lfsd: next-cycle check failed");

`else

`define LFSD_ASSERT_IMPLIES(label, clock, resetn, ante, cons)

`define LFSD_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

/* design/lfsd_pkg.sv */
// Types, constants and lookup functions for the line follower stepper drive.
package lfsd_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_STRAIGHT  = 2'd1,
        MODE_LEFT_COR  = 2'd2,
        MODE_RIGHT_COR = 2'd3
    } drive_mode_t;

    localparam int unsigned PERIOD_W     = 16;
    localparam int unsigned PHASE_W      = 4;
    localparam int unsigned SENSOR_W     = 8;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;
    localparam logic [PHASE_W-1:0]  PHASE_FALLBACK = 4'hC;

    typedef logic [PHASE_W-1:0] phase_t;

    function automatic drive_mode_t classify(input logic [SENSOR_W-1:0] s);
        drive_mode_t m;
        unique case (s) inside
            8'h0F, 8'h0E, 8'h07: m = MODE_STRAIGHT;
            8'h0B, 8'h03:        m = MODE_RIGHT_COR;
            8'h0D, 8'h0C:        m = MODE_LEFT_COR;
            default:             m = MODE_IDLE;
        endcase
        return m;
    endfunction

    // left sequence: 9 8 C 4 6 2 3 1
    function automatic phase_t left_step(input phase_t p);
        phase_t n;
        unique case (p)
            4'h9:    n = 4'h8;
            4'h8:    n = 4'hC;
            4'hC:    n = 4'h4;
            4'h4:    n = 4'h6;
            4'h6:    n = 4'h2;
            4'h2:    n = 4'h3;
            4'h3:    n = 4'h1;
            4'h1:    n = 4'h9;
            default: n = PHASE_FALLBACK;
        endcase
        return n;
    endfunction

    // right sequence: 9 1 3 2 6 4 C 8
    function automatic phase_t right_step(input phase_t p);
        phase_t n;
        unique case (p)
            4'h9:    n = 4'h1;
            4'h1:    n = 4'h3;
            4'h3:    n = 4'h2;
            4'h2:    n = 4'h6;
            4'h6:    n = 4'h4;
            4'h4:    n = 4'hC;
            4'hC:    n = 4'h8;
            4'h8:    n = 4'h9;
            default: n = PHASE_FALLBACK;
        endcase
        return n;
    endfunction

endpackage

/* design/line_follower_stepper_drive.sv */
// Line follower stepper drive: prescaler, sensor classification and half-step sequencing.
//
// Input channel (in_valid, in_stall, op, sensor_bits): op 0 is a timer tick, op 1 a
// start/stop press. A transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid, out_stall, motor_drive, mode, stepped, running): one result
// per input transfer, in order; a transfer happens with out_valid high and out_stall low.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): writes update_period; cfg_ready
// is always high. Write it only while no item is in flight.
// An item passes from the input register to the result register, from which its result
// transfers. Throughput: one item per cycle while the receiver does not stall, set by the
// single state update that happens as an item moves from the input register to the result
// register.
// Reset clears the prescaler, both phases, the skip parities and the run flag, sets the
// mode to straight and the period to 50. When the receiver stalls, the result register
// holds; an item in the input register waits, in_stall high, until the result leaves.
`include "line_follower_stepper_drive_defines.svh"

module line_follower_stepper_drive (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [lfsd_pkg::SENSOR_W-1:0]  sensor_bits,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     motor_drive,
    output logic [1:0]                     mode,
    output logic                           stepped,
    output logic                           running,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfsd_pkg::PERIOD_W-1:0]  cfg_data
);
    import lfsd_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] tick_count_reg, tick_count_next;
    phase_t              left_phase_reg, left_phase_next;
    phase_t              right_phase_reg, right_phase_next;
    drive_mode_t         drive_mode_reg, drive_mode_next;
    logic                left_par_reg, left_par_next;
    logic                right_par_reg, right_par_next;
    logic                run_reg, run_next;

    logic                s1_valid_reg;
    logic                s1_op_reg;
    logic [SENSOR_W-1:0] s1_sensor_reg;

    logic                out_valid_reg;
    logic [7:0]          out_drive_reg;
    logic [1:0]          out_mode_reg;
    logic                out_stepped_reg;
    logic                out_running_reg;

    logic                out_load;
    logic                s1_fire;
    logic                in_fire;
    logic                upd;
    logic [PERIOD_W-1:0] tick_inc;
    drive_mode_t         cls;

    assign cfg_ready = 1'b1;

    assign out_load = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        tick_inc         = tick_count_reg + 16'd1;
        cls              = classify(s1_sensor_reg);
        upd              = !s1_op_reg && run_reg && (tick_inc == period_reg);
        run_next         = run_reg ^ s1_op_reg;
        tick_count_next  = tick_count_reg;
        left_phase_next  = left_phase_reg;
        right_phase_next = right_phase_reg;
        drive_mode_next  = drive_mode_reg;
        left_par_next    = left_par_reg;
        right_par_next   = right_par_reg;
        if (!s1_op_reg && run_reg)
        begin
            tick_count_next = upd ? '0 : tick_inc;
        end
        if (upd)
        begin
            drive_mode_next = cls;
            case (cls)
                MODE_STRAIGHT:
                begin
                    left_phase_next  = left_step(left_phase_reg);
                    right_phase_next = right_step(right_phase_reg);
                end
                MODE_LEFT_COR:
                begin
                    right_phase_next = right_step(right_phase_reg);
                    if (left_par_reg)
                    begin
                        left_phase_next = left_step(left_phase_reg);
                    end
                    left_par_next = !left_par_reg;
                end
                MODE_RIGHT_COR:
                begin
                    left_phase_next = left_step(left_phase_reg);
                    if (right_par_reg)
                    begin
                        right_phase_next = right_step(right_phase_reg);
                    end
                    right_par_next = !right_par_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            period_reg <= cfg_data;
        end
    end

    // advance drive state as each item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            left_phase_reg  <= '0;
            right_phase_reg <= '0;
            drive_mode_reg  <= MODE_STRAIGHT;
            left_par_reg    <= 1'b0;
            right_par_reg   <= 1'b0;
            run_reg         <= 1'b0;
        end
        else if (s1_fire)
        begin
            tick_count_reg  <= tick_count_next;
            left_phase_reg  <= left_phase_next;
            right_phase_reg <= right_phase_next;
            drive_mode_reg  <= drive_mode_next;
            left_par_reg    <= left_par_next;
            right_par_reg   <= right_par_next;
            run_reg         <= run_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || out_load)
            begin
                s1_valid_reg <= in_fire;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg     <= op;
            s1_sensor_reg <= sensor_bits;
        end
        if (s1_fire)
        begin
            out_drive_reg   <= {right_phase_next, left_phase_next};
            out_mode_reg    <= drive_mode_next;
            out_stepped_reg <= upd;
            out_running_reg <= run_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign motor_drive = out_drive_reg;
    assign mode        = out_mode_reg;
    assign stepped     = out_stepped_reg;
    assign running     = out_running_reg;

    `LFSD_ASSERT_IMPLIES(a_step_needs_run, clk, rst_n, out_valid_reg && out_stepped_reg, out_running_reg)
    `LFSD_ASSERT_IMPLIES(a_stall_only_when_blocked, clk, rst_n, in_stall, out_valid_reg && out_stall)
    `LFSD_ASSERT_NEXT(a_update_clears_count, clk, rst_n, s1_fire && upd, tick_count_reg == '0)

endmodule
